// ----- hw/rtl/vqncl_pkg.sv -----
// Package for the nearest-codeword search block: field widths, defaults,
// command and state codes, and the tag that follows a codeword down the pipe.
// No dependencies.
package vqncl_pkg;

    // Default configuration
    localparam int CODEBOOK_DEPTH_DEF = 128;
    localparam int VECTOR_LENGTH_DEF  = 12;
    localparam int COEFF_BITS_DEF     = 16;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int ENTRY_W = 7;
    localparam int POS_W   = 4;
    localparam int LABEL_W = 3;
    localparam int CFG_W   = 8;
    localparam int DIST_W  = 36;

    localparam logic [CFG_W-1:0]  ENTRIES_RESET = 8'd128;
    localparam logic [DIST_W-1:0] DIST_MAX      = '1;

    // Input commands (code 3 is unused and ignored)
    typedef enum logic [CMD_W-1:0] {
        CMD_CW_WR    = 2'd0,
        CMD_LABEL_WR = 2'd1,
        CMD_QUERY    = 2'd2
    } t_cmd;

    // Search sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    // Control that travels alongside one codeword through the distance pipe
    typedef struct packed {
        logic               vld;
        logic               first;
        logic               last;
        logic [ENTRY_W-1:0] ent;
        logic [LABEL_W-1:0] lab;
    } t_tag;

endpackage

// ----- hw/rtl/vqncl_if.sv -----
// Valid/ready channel interfaces for the nearest-codeword search block:
// the input item channel and the search result channel.
// Depends on vqncl_pkg.
interface vqncl_item_if import vqncl_pkg::*; #(
    parameter int COEFF_BITS = COEFF_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic [ENTRY_W-1:0]           entry;
    logic [POS_W-1:0]             position;
    logic signed [COEFF_BITS-1:0] value;
    logic [LABEL_W-1:0]           class_label;
    logic                         end_of_query;

    modport source (
        output valid, cmd, entry, position, value, class_label, end_of_query,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry, position, value, class_label, end_of_query,
        output ready
    );
endinterface

interface vqncl_result_if import vqncl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [LABEL_W-1:0] best_label;
    logic [ENTRY_W-1:0] best_entry;
    logic [DIST_W-1:0]  best_distance;

    modport source (
        output valid, found, best_label, best_entry, best_distance,
        input  ready
    );
    modport sink (
        input  valid, found, best_label, best_entry, best_distance,
        output ready
    );
endinterface

// ----- hw/rtl/vq_nearest_codeword_label_top.sv -----
// Nearest-codeword search with class labels: codebook memory, label memory,
// query registers, search sequencer and result register.
// Depends on vqncl_pkg, vqncl_if and vqncl_dist.
//
// Codeword coefficient, label and query coefficient items are accepted back
// to back while the block is idle. The item that ends a query starts a
// search that reads one codeword row and its label per cycle from the
// codebook memories through a single row read port, and the block stays
// busy until the distance pipeline behind it drains. A finished result sits in an
// output register; further items are accepted while it waits, and a second
// search holds its result until the register is free. Memories need no
// clearing pass: unwritten entries are never meant to be searched.
module vq_nearest_codeword_label_top import vqncl_pkg::*; #(
    parameter int CODEBOOK_DEPTH = CODEBOOK_DEPTH_DEF,
    parameter int VECTOR_LENGTH  = VECTOR_LENGTH_DEF,
    parameter int COEFF_BITS     = COEFF_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    vqncl_item_if.sink         i_item,
    vqncl_result_if.source     o_result
);

    localparam int AW = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;

    typedef logic [VECTOR_LENGTH-1:0][COEFF_BITS-1:0] t_row;

    // Storage
    t_row               r_cw_mem  [CODEBOOK_DEPTH];
    logic [LABEL_W-1:0] r_lab_mem [CODEBOOK_DEPTH];
    t_row               r_query;
    t_row               r_row_rd;
    logic [LABEL_W-1:0] r_lab_rd;

    // Control
    logic [CFG_W-1:0]   r_entries;
    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_last;
    t_tag               r_rd_tag;

    // Running best and output register
    logic               r_found;
    logic [LABEL_W-1:0] r_best_lab;
    logic [ENTRY_W-1:0] r_best_ent;
    logic [DIST_W-1:0]  r_best_dist;
    logic               r_out_vld;
    logic               r_out_found;
    logic [LABEL_W-1:0] r_out_lab;
    logic [ENTRY_W-1:0] r_out_ent;
    logic [DIST_W-1:0]  r_out_dist;

    logic               w_acc;
    t_cmd               w_cmd;
    logic               w_ent_ok;
    logic               w_pos_ok;
    logic [AW-1:0]      w_addr;
    logic [31:0]        w_cnt;
    logic               w_cnt_zero;
    logic               w_start;
    logic               w_issue;
    logic               w_out_load;
    t_tag               w_dist_tag;
    t_tag               w_fin;
    logic [DIST_W-1:0]  w_fin_dist;
    logic               w_fin_done;

    // Transaction decode
    assign w_acc      = i_item.valid && i_item.ready;
    assign w_cmd      = t_cmd'(i_item.cmd);
    assign w_ent_ok   = 32'(i_item.entry) < CODEBOOK_DEPTH;
    assign w_pos_ok   = 32'(i_item.position) < VECTOR_LENGTH;
    assign w_addr     = AW'(i_item.entry);
    assign w_cnt      = (32'(r_entries) > CODEBOOK_DEPTH) ? CODEBOOK_DEPTH
                                                          : 32'(r_entries);
    assign w_cnt_zero = (w_cnt == 32'd0);
    assign w_start    = w_acc && (w_cmd == CMD_QUERY) && i_item.end_of_query;
    assign w_issue    = (r_state == ST_ISSUE);
    assign w_fin_done = w_fin.vld && w_fin.last;
    assign w_out_load = (r_state == ST_HOLD) && (!r_out_vld || o_result.ready);

    assign i_item.ready = (r_state == ST_IDLE);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (i_cfg_wr_en) begin
            r_entries <= i_cfg_wr_data;
        end
    end

    // Codebook memory: coefficient-lane writes, one full row read
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_cmd == CMD_CW_WR) && w_ent_ok && w_pos_ok) begin
            for (int k = 0; k < VECTOR_LENGTH; k++) begin
                if (32'(i_item.position) == k) begin
                    r_cw_mem[w_addr][k] <= i_item.value;
                end
            end
        end
        if (w_issue) begin
            r_row_rd <= r_cw_mem[r_idx];
        end
    end

    // Label memory
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_cmd == CMD_LABEL_WR) && w_ent_ok) begin
            r_lab_mem[w_addr] <= i_item.class_label;
        end
        if (w_issue) begin
            r_lab_rd <= r_lab_mem[r_idx];
        end
    end

    // Query registers, kept across searches
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_cmd == CMD_QUERY) && w_pos_ok) begin
            for (int k = 0; k < VECTOR_LENGTH; k++) begin
                if (32'(i_item.position) == k) begin
                    r_query[k] <= i_item.value;
                end
            end
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = w_cnt_zero ? ST_HOLD : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_idx == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_fin_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Entry counter and read-side tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_last   <= '0;
            r_rd_tag <= '0;
        end else begin
            if (w_start) begin
                r_idx  <= '0;
                r_last <= AW'(w_cnt - 32'd1);
            end else if (w_issue) begin
                r_idx <= r_idx + AW'(1);
            end
            r_rd_tag.vld   <= w_issue;
            r_rd_tag.first <= (r_idx == '0);
            r_rd_tag.last  <= (r_idx == r_last);
            r_rd_tag.ent   <= ENTRY_W'(r_idx);
            r_rd_tag.lab   <= '0;
        end
    end

    // Label joins the tag as the row leaves the memory
    always_comb begin
        w_dist_tag     = r_rd_tag;
        w_dist_tag.lab = r_lab_rd;
    end

    vqncl_dist #(
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .COEFF_BITS    (COEFF_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (r_row_rd),
        .i_query (r_query),
        .i_tag   (w_dist_tag),
        .o_tag   (w_fin),
        .o_dist  (w_fin_dist)
    );

    // Running minimum; strict compare keeps the earliest index on ties
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_found     <= !w_cnt_zero;
            r_best_lab  <= '0;
            r_best_ent  <= '0;
            r_best_dist <= '0;
        end else if (w_fin.vld && (w_fin.first || (w_fin_dist < r_best_dist))) begin
            r_best_lab  <= w_fin.lab;
            r_best_ent  <= w_fin.ent;
            r_best_dist <= w_fin_dist;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= r_found;
            r_out_lab   <= r_best_lab;
            r_out_ent   <= r_best_ent;
            r_out_dist  <= r_best_dist;
        end
    end

    assign o_result.valid         = r_out_vld;
    assign o_result.found         = r_out_found;
    assign o_result.best_label    = r_out_lab;
    assign o_result.best_entry    = r_out_ent;
    assign o_result.best_distance = r_out_dist;

    // Checks
    a_fin_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin.vld |-> (r_state == ST_ISSUE || r_state == ST_DRAIN))
        else $error("distance result outside a search");

    a_drain_waits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && !w_fin_done) |=> (r_state == ST_DRAIN))
        else $error("search ended before its last entry");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_idx <= r_last))
        else $error("issue index passed the last entry");

    a_hold_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD && r_out_vld && !o_result.ready) |=> (r_state == ST_HOLD))
        else $error("held result dropped while output busy");

endmodule

// ----- hw/rtl/vqncl_dist.sv -----
// Squared Euclidean distance pipeline: one codeword row per cycle against the
// stored query, one multiplier per lane, then a registered adder tree.
// Depends on vqncl_pkg.
module vqncl_dist import vqncl_pkg::*; #(
    parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF,
    parameter int COEFF_BITS    = COEFF_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [VECTOR_LENGTH-1:0][COEFF_BITS-1:0] i_row,
    input  logic [VECTOR_LENGTH-1:0][COEFF_BITS-1:0] i_query,
    input  t_tag                                     i_tag,
    output t_tag                                     o_tag,
    output logic [DIST_W-1:0]                        o_dist
);

    localparam int DFW = COEFF_BITS + 1;
    localparam int SQW = 2 * DFW;
    localparam int XW  = (SQW > DIST_W) ? SQW : DIST_W;
    localparam int LV  = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 0;
    localparam int NP  = 1 << LV;
    localparam int SW  = DIST_W + LV;
    localparam int NT  = LV + 2;

    logic signed [DFW-1:0] r_diff [VECTOR_LENGTH];
    logic [SW-1:0]         r_tree [LV+1][NP];
    t_tag                  r_tag  [NT];
    logic [SW-1:0]         w_sq   [VECTOR_LENGTH];

    // Lane differences, sign-extended by one bit
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < VECTOR_LENGTH; k++) begin
            r_diff[k] <= $signed({i_query[k][COEFF_BITS-1], i_query[k]})
                       - $signed({i_row[k][COEFF_BITS-1], i_row[k]});
        end
    end

    // Lane squares, clamped to the distance range
    always_comb begin
        logic signed [SQW-1:0] prod;
        logic [XW-1:0]         prod_x;
        for (int k = 0; k < VECTOR_LENGTH; k++) begin
            prod   = r_diff[k] * r_diff[k];
            prod_x = XW'($unsigned(prod));
            if (prod_x > XW'(DIST_MAX)) begin
                w_sq[k] = SW'(DIST_MAX);
            end else begin
                w_sq[k] = SW'(prod_x);
            end
        end
    end

    // Tree leaves, padded with zeros
    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < VECTOR_LENGTH) begin : g_sq
            always_ff @(posedge i_clk) begin
                r_tree[0][j] <= w_sq[j];
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_tree[0][j] <= '0;
            end
        end
    end

    // Pairwise adder levels, one register each
    for (genvar lv = 1; lv <= LV; lv++) begin : g_level
        for (genvar j = 0; j < NP; j++) begin : g_node
            if (j < (NP >> lv)) begin : g_add
                always_ff @(posedge i_clk) begin
                    r_tree[lv][j] <= r_tree[lv-1][2*j] + r_tree[lv-1][2*j+1];
                end
            end else begin : g_unused
                always_ff @(posedge i_clk) begin
                    r_tree[lv][j] <= '0;
                end
            end
        end
    end

    // Tag shift line matching the datapath depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NT; s++) begin
                r_tag[s] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < NT; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_tag  = r_tag[NT-1];
    assign o_dist = (r_tree[LV][0] > SW'(DIST_MAX)) ? DIST_MAX
                                                    : DIST_W'(r_tree[LV][0]);

endmodule
